### rtl/conv3x3_zero_pad_stream_top_defines.svh
// assertion macros used by the checker file
`ifndef CONV3X3_ZERO_PAD_STREAM_TOP_DEFINES_SVH
`define CONV3X3_ZERO_PAD_STREAM_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define C3ZP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define C3ZP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/c3zp_pkg.sv
// shared constants, types and helpers of the 3x3 convolution stream block
package c3zp_pkg;

  // image geometry
  localparam int MaxWidth  = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int WEffW     = ColW + 1;
  localparam int RowW      = 17;
  localparam int WidthRegW = 11;
  localparam int HeightW   = 16;
  localparam int Taps      = 3;

  // data widths
  localparam int PixW     = 8;
  localparam int CoefW    = 8;
  localparam int CoefRowW = Taps * CoefW;
  localparam int ProdW    = CoefW + PixW + 1;
  localparam int SumW     = 20;
  localparam int OutDataW = 24;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [CoefRowW-1:0]  CoefReset   = 24'hFF0001;
  localparam logic [WidthRegW-1:0] WidthReset  = 11'd512;
  localparam logic [HeightW-1:0]   HeightReset = 16'd512;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEFF_TOP    = 3'd0,
    REG_COEFF_MID    = 3'd1,
    REG_COEFF_BOT    = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } cfg_reg_e;

  // position info for one word, decided when it is taken in
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            res_valid;
    logic            last;
    logic            top_out;
    logic            bot_out;
    logic            left_out;
    logic            right_out;
  } pos_t;

  // new window column: two line delays and the current pixel
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } taps_t;

  // signed coefficient k (0 = left) of a packed kernel row
  function automatic logic signed [CoefW-1:0] coef_at(logic [CoefRowW-1:0] row_word,
                                                      int unsigned k);
    return $signed(row_word[k*CoefW +: CoefW]);
  endfunction

endpackage

### rtl/conv3x3_zero_pad_stream_top.sv
// 3x3 zero-padded convolution over a raster pixel stream
//
// Pixels enter on the s_axis channel in raster order, one word per clock;
// tuser set marks a fill word that counts as a zero pixel. After a frame's
// last pixel, frame_width + 1 fill words drain the final row. Each result
// on m_axis is the signed 3x3 sum for the pixel one row and one pixel
// behind the word that completes it; tlast marks the frame's bottom-right
// result. The first frame_width + 1 words of a frame give no result.
// Kernel rows and frame size are written on the cfg channel (always ready)
// while the block is idle.
// Throughput is one word per clock while m_axis keeps up. A result reaches
// the output register in order: the line memories are read when the word
// that completes it is taken, the window products are registered when that
// word retires and the adder tree then loads the output register.
// Reset clears the position counters, the window and the pipeline valids and
// restores default coefficients and a 512 x 512 frame; the line memories
// are not cleared. When m_axis stalls, the result register holds and words
// that give no result still pass; s_axis_tready falls only once all three
// stages hold results.
module conv3x3_zero_pad_stream_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [c3zp_pkg::PixW-1:0]         s_axis_tdata,   // [7:0] pixel_value
  input  logic                              s_axis_tuser,   // [0] drain_fill
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [c3zp_pkg::OutDataW-1:0]     m_axis_tdata,   // [19:0] conv_sum, rest zero
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [c3zp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [c3zp_pkg::CfgDataW-1:0]     cfg_data_i
);
  import c3zp_pkg::*;

  logic [CoefRowW-1:0]  coef_top_q, coef_mid_q, coef_bot_q;
  logic [WidthRegW-1:0] width_q;
  logic [HeightW-1:0]   height_q;
  logic                 accept, commit, take, s1_valid;
  logic [PixW-1:0]      pix;
  pos_t                 pos, s1_pos;
  taps_t                taps;
  logic [SumW-1:0]      sum;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_top_q <= CoefReset;
      coef_mid_q <= CoefReset;
      coef_bot_q <= CoefReset;
      width_q    <= WidthReset;
      height_q   <= HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COEFF_TOP:    coef_top_q <= cfg_data_i[CoefRowW-1:0];
        REG_COEFF_MID:    coef_mid_q <= cfg_data_i[CoefRowW-1:0];
        REG_COEFF_BOT:    coef_bot_q <= cfg_data_i[CoefRowW-1:0];
        REG_FRAME_WIDTH:  width_q    <= cfg_data_i[WidthRegW-1:0];
        REG_FRAME_HEIGHT: height_q   <= cfg_data_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: the input stage retires into the products or drops
  assign commit        = s1_valid && (!s1_pos.res_valid || take);
  assign s_axis_tready = !s1_valid || commit;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pix           = s_axis_tuser ? '0 : s_axis_tdata;

  c3zp_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .width_i  (width_q),
    .height_i (height_q),
    .pos_o    (pos)
  );

  c3zp_linebuf u_linebuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .pix_i      (pix),
    .pos_i      (pos),
    .commit_i   (commit),
    .s1_valid_o (s1_valid),
    .s1_pos_o   (s1_pos),
    .taps_o     (taps)
  );

  c3zp_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_i   (commit),
    .pos_i      (s1_pos),
    .taps_i     (taps),
    .coef_top_i (coef_top_q),
    .coef_mid_i (coef_mid_q),
    .coef_bot_i (coef_bot_q),
    .take_o     (take),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .sum_o      (sum),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OutDataW-SumW){1'b0}}, sum};

endmodule

### rtl/c3zp_pos.sv
// raster position counters and output-position decode
module c3zp_pos (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [c3zp_pkg::WidthRegW-1:0]   width_i,
  input  logic [c3zp_pkg::HeightW-1:0]     height_i,
  output c3zp_pkg::pos_t                   pos_o
);
  import c3zp_pkg::*;

  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [WEffW-1:0]   w_eff;
  logic [HeightW-1:0] h_eff;
  logic [RowW-1:0]    h_p1, h_row;
  logic               restart;
  logic [ColW-1:0]    col;
  logic [RowW-1:0]    row, pr;
  logic [ColW-1:0]    pc;
  logic               valid;

  // clamp the programmed frame size
  always_comb begin
    if (width_i == '0) begin
      w_eff = WEffW'(1);
    end else if (32'(width_i) > MaxWidth) begin
      w_eff = WEffW'(MaxWidth);
    end else begin
      w_eff = WEffW'(width_i);
    end
    h_eff = (height_i == '0) ? HeightW'(1) : height_i;
    h_row = RowW'(h_eff);
    h_p1  = h_row + RowW'(1);
  end

  // position of this word and of the pixel whose result it completes
  always_comb begin
    restart = (WEffW'(col_q) >= w_eff) || (row_q > h_p1) ||
              ((row_q == h_p1) && (col_q != '0));
    row = restart ? '0 : row_q;
    col = restart ? '0 : col_q;

    if (col != '0) begin
      valid = (row != '0);
      pr    = row - RowW'(1);
      pc    = col - ColW'(1);
    end else begin
      valid = (row >= RowW'(2));
      pr    = row - RowW'(2);
      pc    = ColW'(w_eff - WEffW'(1));
    end
    valid = valid && (pr < h_row);

    pos_o.col       = col;
    pos_o.res_valid = valid;
    pos_o.top_out   = (pr == '0);
    pos_o.bot_out   = (pr == h_row - RowW'(1));
    pos_o.left_out  = (pc == '0);
    pos_o.right_out = (WEffW'(pc) == w_eff - WEffW'(1));
    pos_o.last      = pos_o.bot_out && pos_o.right_out;

    // advance; the frame's last result starts a new frame
    if (WEffW'(col) + WEffW'(1) >= w_eff) begin
      col_d = '0;
      row_d = row + RowW'(1);
    end else begin
      col_d = col + ColW'(1);
      row_d = row;
    end
    if (valid && pos_o.last) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // counters move on every taken word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### rtl/c3zp_linebuf.sv
// two line delays in block memory plus the input stage register
module c3zp_linebuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [c3zp_pkg::PixW-1:0]   pix_i,
  input  c3zp_pkg::pos_t              pos_i,
  input  logic                        commit_i,
  output logic                        s1_valid_o,
  output c3zp_pkg::pos_t              s1_pos_o,
  output c3zp_pkg::taps_t             taps_o
);
  import c3zp_pkg::*;

  logic [PixW-1:0] line1_mem [MaxWidth];
  logic [PixW-1:0] line2_mem [MaxWidth];

  logic            s1_valid_q;
  pos_t            s1_pos_q;
  logic [PixW-1:0] s1_x_q;
  logic [PixW-1:0] rd1_q, rd2_q;
  logic            fwd_q;
  logic [PixW-1:0] fwd1_q, fwd2_q;
  logic [PixW-1:0] a_cur, b_cur;

  // data of the same column still waiting to be written wins over memory
  assign a_cur = fwd_q ? fwd1_q : rd1_q;
  assign b_cur = fwd_q ? fwd2_q : rd2_q;

  // read on intake, write back when the stage retires
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd1_q <= line1_mem[pos_i.col];
      rd2_q <= line2_mem[pos_i.col];
    end
    if (commit_i) begin
      line1_mem[s1_pos_q.col] <= s1_x_q;
      line2_mem[s1_pos_q.col] <= a_cur;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_pos_q <= pos_i;
      s1_x_q   <= pix_i;
      fwd_q    <= s1_valid_q && (s1_pos_q.col == pos_i.col);
      fwd1_q   <= s1_x_q;
      fwd2_q   <= a_cur;
    end
  end

  // stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept_i) begin
      s1_valid_q <= 1'b1;
    end else if (commit_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_pos_o   = s1_pos_q;
  assign taps_o.top = b_cur;
  assign taps_o.mid = a_cur;
  assign taps_o.bot = s1_x_q;

endmodule

### rtl/c3zp_mac.sv
// 3x3 window, masked products and the result register
module c3zp_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            commit_i,
  input  c3zp_pkg::pos_t                  pos_i,
  input  c3zp_pkg::taps_t                 taps_i,
  input  logic [c3zp_pkg::CoefRowW-1:0]   coef_top_i,
  input  logic [c3zp_pkg::CoefRowW-1:0]   coef_mid_i,
  input  logic [c3zp_pkg::CoefRowW-1:0]   coef_bot_i,
  output logic                            take_o,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [c3zp_pkg::SumW-1:0]       sum_o,
  output logic                            last_o
);
  import c3zp_pkg::*;

  logic [PixW-1:0]         win_q [Taps][Taps];
  logic [PixW-1:0]         win_d [Taps][Taps];
  logic [CoefRowW-1:0]     coef_rows [Taps];
  logic [Taps-1:0]         row_en, col_en;
  logic signed [ProdW-1:0] prod_d [Taps][Taps];
  logic signed [ProdW-1:0] prod_q [Taps][Taps];
  logic signed [SumW:0]    row_sum [Taps];
  logic signed [SumW:0]    total;
  logic                    s2_valid_q, s2_last_q;
  logic                    out_valid_q, out_last_q;
  logic [SumW-1:0]         out_sum_q;
  logic                    out_free, s2_free;

  assign coef_rows[0] = coef_top_i;
  assign coef_rows[1] = coef_mid_i;
  assign coef_rows[2] = coef_bot_i;

  // edge masks: taps outside the image count as zero
  assign row_en = {~pos_i.bot_out, 1'b1, ~pos_i.top_out};
  assign col_en = {~pos_i.right_out, 1'b1, ~pos_i.left_out};

  // shifted window and its masked products
  always_comb begin
    logic signed [ProdW-1:0] cx, px;
    for (int i = 0; i < Taps; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = taps_i.top;
    win_d[1][2] = taps_i.mid;
    win_d[2][2] = taps_i.bot;
    for (int i = 0; i < Taps; i++) begin
      for (int k = 0; k < Taps; k++) begin
        cx = ProdW'(coef_at(coef_rows[i], k));
        px = ProdW'($signed({1'b0, win_d[i][k]}));
        prod_d[i][k] = (row_en[i] && col_en[k]) ? cx * px : '0;
      end
    end
  end

  // window moves with every retired word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Taps; i++) begin
        for (int k = 0; k < Taps; k++) begin
          win_q[i][k] <= '0;
        end
      end
    end else if (commit_i) begin
      win_q <= win_d;
    end
  end

  // handshake between product stage and result register
  assign out_free = !out_valid_q || m_ready_i;
  assign s2_free  = !s2_valid_q || out_free;
  assign take_o   = s2_free;

  // product stage payload
  always_ff @(posedge clk_i) begin
    if (commit_i && pos_i.res_valid) begin
      prod_q    <= prod_d;
      s2_last_q <= pos_i.last;
    end
  end

  // adder tree: row sums then total
  always_comb begin
    for (int i = 0; i < Taps; i++) begin
      row_sum[i] = (SumW+1)'(prod_q[i][0]) + (SumW+1)'(prod_q[i][1]) +
                   (SumW+1)'(prod_q[i][2]);
    end
    total = row_sum[0] + row_sum[1] + row_sum[2];
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_free) begin
      out_sum_q  <= total[SumW-1:0];
      out_last_q <= s2_last_q;
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit_i && pos_i.res_valid) begin
        s2_valid_q <= 1'b1;
      end else if (out_free) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_valid_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign sum_o     = out_sum_q;
  assign last_o    = out_last_q;

endmodule

### rtl/c3zp_checker.sv
// port-level checks for the convolution stream block, bound to the top level
`include "conv3x3_zero_pad_stream_top_defines.svh"

module c3zp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tready,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [c3zp_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              m_axis_tlast
);

  // a stalled result word holds still
  `C3ZP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "result word changed while stalled")

  // input backpressure only comes from a stalled full pipeline
  `C3ZP_ASSERT_NOW(a_in_stall, !s_axis_tready,
    m_axis_tvalid && !m_axis_tready,
    "input stalled while output side is free")

  // every nine-tap sum lies within the coefficient and pixel bounds
  `C3ZP_ASSERT_NOW(a_sum_range, m_axis_tvalid,
    (m_axis_tdata[23:20] == 4'd0) && ($signed(m_axis_tdata[19:0]) >= -20'sd293760) &&
    ($signed(m_axis_tdata[19:0]) <= 20'sd291465),
    "result sum out of range")

endmodule

bind conv3x3_zero_pad_stream_top c3zp_checker u_c3zp_checker (.*);

### tb/sv/conv3x3_zero_pad_stream_top_test.sv
// self-checking testbench for the 3x3 zero-padded convolution stream block
`timescale 1ns / 100ps

module conv3x3_zero_pad_stream_top_test;
  import c3zp_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int SettleTicks = 8;
  localparam int HoldCycles  = 300;
  localparam int RandWords   = 200;
  localparam int ShowErrors  = 10;

  // one input word: pixel and fill flag
  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            fill;
  } pix_word_t;

  // one expected output word
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            last;
  } conv_result_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [PixW-1:0]     s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // stimulus and scoreboard storage
  pix_word_t    pending_words[$];
  conv_result_t expected_sums[$];
  int           words_queued   = 0;
  int           words_accepted = 0;
  int           mismatches     = 0;
  int           cycle_cnt      = 0;
  int           src_idle_pct   = 11;
  int           snk_idle_pct   = 11;
  bit           hold_go        = 1'b0;
  int           hold_cnt       = 0;

  // shadow of the block's registers and state
  logic [CoefRowW-1:0]  kern_row[Taps];
  logic [WidthRegW-1:0] width_reg;
  logic [HeightW-1:0]   height_reg;
  logic [PixW-1:0]      line_mem[2*MaxWidth];
  logic [PixW-1:0]      win[Taps][Taps];
  int unsigned          row_pos;
  int unsigned          col_pos;

  conv3x3_zero_pad_stream_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // clamp width and height the way the block reads them
  function automatic int unsigned eff_width(logic [WidthRegW-1:0] w);
    if (w < 1) return 1;
    if (w > MaxWidth) return MaxWidth;
    return 32'(w);
  endfunction

  function automatic int unsigned eff_height(logic [HeightW-1:0] h);
    return (h < 1) ? 1 : 32'(h);
  endfunction

  // shadow state after reset
  function void shadow_reset();
    for (int i = 0; i < Taps; i++) begin
      kern_row[i] = 24'hFF0001;
      for (int k = 0; k < Taps; k++) win[i][k] = '0;
    end
    width_reg  = 11'd512;
    height_reg = 16'd512;
    for (int i = 0; i < 2*MaxWidth; i++) line_mem[i] = '0;
    row_pos = 0;
    col_pos = 0;
  endfunction

  // advance the shadow by one accepted word, queue its result if any
  function void kernel_sum_predict(logic [PixW-1:0] pix, logic fill);
    int unsigned  w, h, row, col, pr, pc;
    logic [PixW-1:0] x, a, b;
    logic signed [CoefW-1:0] cb;
    bit           ok, last;
    int           sum;
    conv_result_t res;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    x = fill ? '0 : pix;
    // counters beyond the current frame restart a new one
    if (col_pos >= w || row_pos > h + 1 || (row_pos == h + 1 && col_pos != 0)) begin
      row_pos = 0;
      col_pos = 0;
    end
    row = row_pos;
    col = col_pos;
    // two line delays
    a = line_mem[col];
    b = line_mem[MaxWidth + col];
    line_mem[MaxWidth + col] = a;
    line_mem[col] = x;
    // shift the window left and insert the new column
    for (int i = 0; i < Taps; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = b;
    win[1][2] = a;
    win[2][2] = x;
    // output position trails one row and one pixel
    if (col >= 1) begin
      ok = row >= 1;
      pr = row - 1;
      pc = col - 1;
    end else begin
      ok = row >= 2;
      pr = row - 2;
      pc = w - 1;
    end
    if (ok && pr >= h) ok = 1'b0;
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1) & 32'h1FFFF;
    end else begin
      col_pos = col + 1;
    end
    if (ok) begin
      last = (pr == h - 1) && (pc == w - 1);
      if (last) begin
        row_pos = 0;
        col_pos = 0;
      end
      sum = 0;
      for (int i = 0; i < Taps; i++) begin
        for (int k = 0; k < Taps; k++) begin
          // taps outside the image count as zero
          if (!((i == 0 && pr < 1) || (i == 2 && pr + 1 >= h) ||
                (k == 0 && pc < 1) || (k == 2 && pc + 1 >= w))) begin
            cb = kern_row[i][k*CoefW +: CoefW];
            sum += int'(cb) * int'(win[i][k]);
          end
        end
      end
      res.sum  = sum[SumW-1:0];
      res.last = last;
      expected_sums.push_back(res);
    end
  endfunction

  // input driver
  always @(posedge clk_i) begin
    pix_word_t wd;
    if (rst_n && (!s_tvalid || s_tready)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        wd = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= wd.pix;
        s_tuser  <= wd.fill;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off counted here
  always @(posedge clk_i) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else if (hold_go && hold_cnt < HoldCycles) begin
      hold_cnt <= hold_cnt + 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor: check results, then predict for an accepted word
  always @(posedge clk_i) begin
    conv_result_t exp_w;
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= ShowErrors)
          $display("unexpected result: tdata %h tlast %b", m_tdata, m_tlast);
      end else begin
        exp_w = expected_sums.pop_front();
        if (m_tdata !== {{(OutDataW-SumW){1'b0}}, exp_w.sum} || m_tlast !== exp_w.last) begin
          mismatches++;
          if (mismatches <= ShowErrors)
            $display("result mismatch: expected sum %h last %b, got tdata %h tlast %b",
                     exp_w.sum, exp_w.last, m_tdata, m_tlast);
        end
      end
    end
    if (rst_n && s_tvalid && s_tready) begin
      kernel_sum_predict(s_tdata, s_tuser);
      words_accepted++;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // wait until every word is taken and every result has arrived
  task automatic settle();
    while (words_accepted != words_queued || expected_sums.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  // register write on the cfg channel, mirrored into the shadow
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COEFF_TOP:    kern_row[0] = val;
      REG_COEFF_MID:    kern_row[1] = val;
      REG_COEFF_BOT:    kern_row[2] = val;
      REG_FRAME_WIDTH:  width_reg   = val[WidthRegW-1:0];
      REG_FRAME_HEIGHT: height_reg  = val[HeightW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_kernel(logic [CoefRowW-1:0] top, logic [CoefRowW-1:0] mid,
                              logic [CoefRowW-1:0] bot);
    write_reg(REG_COEFF_TOP, top);
    write_reg(REG_COEFF_MID, mid);
    write_reg(REG_COEFF_BOT, bot);
  endtask

  task automatic write_size(logic [WidthRegW-1:0] w, logic [HeightW-1:0] h);
    write_reg(REG_FRAME_WIDTH, CfgDataW'(w));
    write_reg(REG_FRAME_HEIGHT, CfgDataW'(h));
  endtask

  task automatic push_word(logic [PixW-1:0] pix, logic fill);
    pix_word_t wd;
    wd.pix  = pix;
    wd.fill = fill;
    pending_words.push_back(wd);
    words_queued++;
  endtask

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CoefRowW-1:0] pick_kernel_row();
    case ($urandom_range(9))
      0:       return 24'h808080;
      1:       return 24'h7F7F7F;
      2:       return 24'h000000;
      default: return CoefRowW'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  // one frame of pixels plus its drain; cut < 0 keeps the whole frame
  task automatic queue_frame(int unsigned w, int unsigned h, int fill_pct, int stray_pct,
                             int skip, int cut);
    int unsigned total;
    total = w * h + w + 1;
    for (int unsigned n = skip; n < total; n++) begin
      if (cut >= 0 && n >= cut) break;
      if (n < w * h)
        push_word(pick_pixel(), $urandom_range(99) < fill_pct);
      else
        push_word(pick_pixel(), !($urandom_range(99) < stray_pct));
    end
  endtask

  // stimulus sequence
  initial begin
    int unsigned w, h;
    int          rand_base, cut;
    shadow_reset();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // small frame with the reset kernel, no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_size(11'd8, 16'd12);
    queue_frame(8, 12, 5, 10, 0, -1);
    settle();

    // most negative sum, with real pixels given during the drain
    src_idle_pct = 11;
    snk_idle_pct = 11;
    write_size(11'd3, 16'd3);
    write_kernel(24'h808080, 24'h808080, 24'h808080);
    repeat (9) push_word(8'hFF, 1'b0);
    push_word(8'hAA, 1'b0);
    push_word(8'h55, 1'b0);
    push_word(8'hFF, 1'b1);
    push_word(8'h00, 1'b1);
    settle();

    // most positive sum
    write_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    repeat (9) push_word(8'hFF, 1'b0);
    repeat (4) push_word(8'h00, 1'b1);
    settle();

    // tallest frame, left unfinished so the next size change restarts it
    src_idle_pct = 11;
    snk_idle_pct = 11;
    write_size(11'd2, 16'hFFFF);
    queue_frame(2, 65535, 5, 10, 0, 40);
    settle();

    // random phases of frames, broken frames and noise
    rand_base = words_queued;
    while (words_queued - rand_base < RandWords) begin
      for (int i = 0; i < Taps; i++)
        if ($urandom_range(99) < 60) write_reg(cfg_reg_e'(i), pick_kernel_row());
      case ($urandom_range(19))
        0:       w = 0;
        1, 2:    w = $urandom_range(7, 40);
        default: w = $urandom_range(1, 6);
      endcase
      h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 5);
      write_size(WidthRegW'(w), HeightW'(h));
      src_idle_pct = ($urandom_range(7) == 0) ? 0 : 11;
      snk_idle_pct = ($urandom_range(7) == 0) ? 0 : 11;
      w = eff_width(width_reg);
      h = eff_height(height_reg);
      if ($urandom_range(19) == 0) begin
        // noise words of any kind
        repeat ($urandom_range(1, 10)) push_word(pick_pixel(), $urandom_range(1) == 1);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          cut = ($urandom_range(9) == 0) ? $urandom_range(1, w * h + w) : -1;
          queue_frame(w, h, 5, 10, 0, cut);
        end
      end
      settle();
    end

    // back-pressure: long output hold while the source keeps offering
    write_size(11'd16, 16'd20);
    write_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_go = 1'b1;
    queue_frame(16, 20, 5, 10, 0, 160);
    // source pause mid-frame until all results are out
    settle();
    src_idle_pct = 11;
    snk_idle_pct = 11;
    queue_frame(16, 20, 5, 10, 160, -1);
    settle();

    if (expected_sums.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
